[design/fbs_pkg.sv]
// ----------------------------------------------------------------------------
// fbs_pkg: shared definitions for the frequency bucket splitter
// Sizes, error codes, the job and result records and the midpoint helper.
// ----------------------------------------------------------------------------
`default_nettype none
package fbs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int MAX_OUT     = MAX_ENTRIES - 1;
    localparam int VAL_W       = 32;
    localparam int NUM_W       = 24;
    localparam int ENT_W       = VAL_W + NUM_W;
    localparam int TOT_W       = 30;
    localparam int TGT_W       = 8;

    localparam logic [TGT_W-1:0] TGT_RESET = 8'd16;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DUP      = 2'd1;
    localparam logic [1:0] ERR_ORDER    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // one finished run handed from the loader to the walker
    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [TOT_W-1:0] total;
        logic [1:0]       err;
    } t_job;

    // one result beat
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    has;
        logic                    last;
        logic [1:0]              err;
    } t_result;

    // floor((a + b) / 2), exact in one extra bit
    function automatic logic signed [VAL_W-1:0] midpoint(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        return s[VAL_W:1];
    endfunction

endpackage
`default_nettype wire

[design/fbs_ram.sv]
// ----------------------------------------------------------------------------
// fbs_ram: generic memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module fbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

[design/fbs_front.sv]
// ----------------------------------------------------------------------------
// fbs_front: entry loader
// Stores entries, sums counts, flags order and overflow errors, and hands a
// job to the walker when the last entry of a run arrives.
// ----------------------------------------------------------------------------
`default_nettype none
module fbs_front import fbs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    output logic                         o_full,
    input  wire logic signed [VAL_W-1:0] i_entry_value,
    input  wire logic [NUM_W-1:0]        i_entry_count,
    input  wire logic                    i_entry_last,
    input  wire logic                    i_walk_busy,
    input  wire logic                    i_job_take,
    output logic                         o_job_valid,
    output t_job                         o_job,
    output logic                         o_we,
    output logic [IDX_W-1:0]             o_waddr,
    output logic [ENT_W-1:0]             o_wdata
);

    logic [CNT_W-1:0]        r_cnt;
    logic [TOT_W-1:0]        r_total;
    logic [1:0]              r_err;
    logic signed [VAL_W-1:0] r_last_v;
    logic                    r_job_valid;
    t_job                    r_job;

    logic             w_acc;
    logic             w_room;
    logic             w_bad_order;
    logic [CNT_W-1:0] n_cnt;
    logic [TOT_W-1:0] n_total;
    logic [1:0]       n_err;

    // the entry store is busy while a job waits or the walker reads it
    assign o_full = r_job_valid | i_walk_busy;
    assign w_acc  = i_push & ~o_full;
    assign w_room = r_cnt < CNT_W'(MAX_ENTRIES);
    assign w_bad_order = (r_cnt != '0) && (i_entry_value <= r_last_v);

    // next run state; first error wins
    always_comb begin
        n_cnt   = w_room ? r_cnt + 1'b1 : r_cnt;
        n_total = w_room ? r_total + TOT_W'(i_entry_count) : r_total;
        if (r_err != ERR_NONE) begin
            n_err = r_err;
        end else if (!w_room) begin
            n_err = ERR_OVERFLOW;
        end else if (w_bad_order) begin
            n_err = ERR_ORDER;
        end else begin
            n_err = ERR_NONE;
        end
    end

    assign o_we    = w_acc & w_room;
    assign o_waddr = r_cnt[IDX_W-1:0];
    assign o_wdata = {i_entry_value, i_entry_count};

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_total     <= '0;
            r_err       <= ERR_NONE;
            r_job_valid <= 1'b0;
        end else begin
            if (i_job_take) begin
                r_job_valid <= 1'b0;
            end
            if (w_acc) begin
                if (w_room) begin
                    r_last_v <= i_entry_value;
                end
                if (i_entry_last) begin
                    r_job_valid <= 1'b1;
                    r_job       <= '{n: n_cnt, total: n_total, err: n_err};
                    r_cnt       <= '0;
                    r_total     <= '0;
                    r_err       <= ERR_NONE;
                end else begin
                    r_cnt   <= n_cnt;
                    r_total <= n_total;
                    r_err   <= n_err;
                end
            end
        end
    end

endmodule
`default_nettype wire

[design/fbs_outq.sv]
// ----------------------------------------------------------------------------
// fbs_outq: result queue
// Two-entry queue that holds result beats until the receiver pops them.
// ----------------------------------------------------------------------------
`default_nettype none
module fbs_outq import fbs_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_result   i_item,
    output logic      o_space,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_result   o_item
);

    t_result    r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_space = (r_cnt != 2'd2);
    assign o_item  = r_mem[r_rp];
    assign w_pop   = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, w_pop};
        end
    end

endmodule
`default_nettype wire

[design/fbs_back.sv]
// ----------------------------------------------------------------------------
// fbs_back: split walker
// Walks the stored entries of a job, collects split points in a buffer,
// checks for duplicates, then sends the answer beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none
module fbs_back import fbs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_take,
    output logic                  o_walk_busy,
    input  wire logic [TGT_W-1:0] i_target,
    output logic                  o_ent_re,
    output logic [IDX_W-1:0]      o_ent_raddr,
    input  wire logic [ENT_W-1:0] i_ent_rdata,
    output logic                  o_res_wr,
    output t_result               o_res,
    input  wire logic             i_res_space
);

    typedef enum logic [3:0] {
        S_IDLE, S_BIG_RD, S_BIG_MUL, S_BIG_ACC, S_SHARE,
        S_W_RD, S_W_CUR, S_W_NXT, S_MID, S_W_MUL, S_W_FIRST,
        S_W_MUL2, S_W_SECOND, S_DONE, S_ONE, S_E_RD
    } t_state;

    t_state                  r_state;
    logic                    r_e_wr;
    logic                    r_mode_mid;
    logic [CNT_W-1:0]        r_i;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_k;
    logic [CNT_W-1:0]        r_len;
    logic [CNT_W-1:0]        r_big_n;
    logic [TOT_W-1:0]        r_total;
    logic [TOT_W-1:0]        r_big_sum;
    logic [TOT_W-1:0]        r_sp;
    logic [TOT_W-1:0]        r_num;
    logic [TGT_W-1:0]        r_bk;
    logic [TGT_W-1:0]        r_sd;
    logic signed [VAL_W-1:0] r_prev_v;
    logic signed [VAL_W-1:0] r_cur_v;
    logic signed [VAL_W-1:0] r_nxt_v;
    logic signed [VAL_W-1:0] r_pv;
    logic [NUM_W-1:0]        r_cur_n;
    logic [NUM_W-1:0]        r_nxt_n;
    logic [31:0]             r_prod;
    logic [TOT_W+TGT_W-1:0]  r_prod2;
    logic                    r_pv_ok;
    logic                    r_dup;
    logic [1:0]              r_err;

    logic signed [VAL_W-1:0] w_q_v;
    logic [NUM_W-1:0]        w_q_n;
    logic [TGT_W-1:0]        w_bk;
    logic [CNT_W-1:0]        w_i_p1;
    logic [CNT_W-1:0]        w_k_p1;
    logic [CNT_W-1:0]        w_lim;
    logic                    w_has_nxt;
    logic                    w_first;
    logic                    w_second;
    logic signed [VAL_W-1:0] w_mid_pc;
    logic signed [VAL_W-1:0] w_mid_cn;
    logic signed [VAL_W-1:0] w_up;
    logic                    w_push;
    logic signed [VAL_W-1:0] w_push_v;
    logic                    w_store;
    logic                    w_sp_re;
    logic [VAL_W-1:0]        w_sp_q;

    assign w_q_v = i_ent_rdata[ENT_W-1 -: VAL_W];
    assign w_q_n = i_ent_rdata[NUM_W-1:0];

    // a target of zero acts as one bucket
    assign w_bk   = (i_target == '0) ? TGT_W'(1) : i_target;
    assign w_i_p1 = r_i + 1'b1;
    assign w_k_p1 = r_k + 1'b1;
    assign w_lim  = (r_len > CNT_W'(MAX_OUT)) ? CNT_W'(MAX_OUT) : r_len;
    assign w_has_nxt = w_i_p1 < r_n;

    // share tests by cross-multiplication
    assign w_first  = (r_prod >= {2'b0, r_sp}) && (r_num > TOT_W'(r_cur_n)) && (r_i != '0);
    assign w_second = w_has_nxt &&
                      ((r_prod2 >= {{TGT_W{1'b0}}, r_sp}) || (r_prod >= {2'b0, r_sp}));

    // midpoints; neighbors one unit apart round up in the walk
    assign w_mid_pc = midpoint(r_prev_v, r_cur_v);
    assign w_mid_cn = midpoint(r_cur_v, r_nxt_v);
    assign w_up     = (w_mid_cn == r_cur_v) ? r_nxt_v : w_mid_cn;

    // split pushes into the buffer
    always_comb begin
        w_push   = 1'b0;
        w_push_v = w_mid_cn;
        case (r_state)
            S_MID: begin
                w_push = 1'b1;
            end
            S_W_FIRST: begin
                w_push   = w_first;
                w_push_v = w_mid_pc;
            end
            S_W_SECOND: begin
                w_push   = w_second;
                w_push_v = w_up;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end
    assign w_store = w_push && (r_len < CNT_W'(MAX_ENTRIES));

    // entry store read address
    assign o_ent_re    = (r_state == S_BIG_RD) || (r_state == S_W_RD) || (r_state == S_W_CUR);
    assign o_ent_raddr = (r_state == S_W_CUR) ? w_i_p1[IDX_W-1:0] : r_i[IDX_W-1:0];

    assign o_job_take  = (r_state == S_IDLE) && i_job_valid;
    assign o_walk_busy = !((r_state == S_IDLE) || (r_state == S_DONE) ||
                           (r_state == S_ONE) || (r_state == S_E_RD));

    // split buffer
    assign w_sp_re = (r_state == S_E_RD) && !r_e_wr && i_res_space;

    fbs_ram #(
        .WIDTH(VAL_W),
        .DEPTH(MAX_ENTRIES)
    ) u_split_ram (
        .i_clk  (i_clk),
        .i_we   (w_store),
        .i_waddr(r_len[IDX_W-1:0]),
        .i_wdata(w_push_v),
        .i_re   (w_sp_re),
        .i_raddr(r_k[IDX_W-1:0]),
        .o_rdata(w_sp_q)
    );

    // result beats
    always_comb begin
        o_res_wr = 1'b0;
        o_res    = '{value: '0, has: 1'b0, last: 1'b1, err: r_err};
        if (r_state == S_ONE) begin
            o_res_wr = i_res_space;
        end else if ((r_state == S_E_RD) && r_e_wr) begin
            o_res_wr = 1'b1;
            o_res    = '{value: w_sp_q, has: 1'b1, last: (w_k_p1 == r_len), err: ERR_NONE};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_e_wr  <= 1'b0;
        end else begin
            if (w_store) begin
                r_len   <= r_len + 1'b1;
                r_pv    <= w_push_v;
                r_pv_ok <= 1'b1;
                if (r_pv_ok && (r_pv == w_push_v)) begin
                    r_dup <= 1'b1;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_n       <= i_job.n;
                        r_total   <= i_job.total;
                        r_bk      <= w_bk;
                        r_i       <= '0;
                        r_len     <= '0;
                        r_pv_ok   <= 1'b0;
                        r_dup     <= 1'b0;
                        r_num     <= '0;
                        r_big_n   <= '0;
                        r_big_sum <= '0;
                        r_err     <= i_job.err;
                        if (i_job.err != ERR_NONE) begin
                            r_state <= S_ONE;
                        end else if ({1'b0, w_bk} >= (TGT_W+1)'(i_job.n)) begin
                            r_mode_mid <= 1'b1;
                            r_state    <= (i_job.n < CNT_W'(2)) ? S_DONE : S_W_RD;
                        end else begin
                            r_mode_mid <= 1'b0;
                            r_state    <= S_BIG_RD;
                        end
                    end
                end
                // count entries that alone fill a bucket
                S_BIG_RD: begin
                    r_state <= S_BIG_MUL;
                end
                S_BIG_MUL: begin
                    r_prod  <= {{(32-NUM_W){1'b0}}, w_q_n} * {{(32-TGT_W){1'b0}}, r_bk};
                    r_cur_n <= w_q_n;
                    r_state <= S_BIG_ACC;
                end
                S_BIG_ACC: begin
                    if (r_prod >= {2'b0, r_total}) begin
                        r_big_n   <= r_big_n + 1'b1;
                        r_big_sum <= r_big_sum + TOT_W'(r_cur_n);
                    end
                    if (w_i_p1 == r_n) begin
                        r_i     <= '0;
                        r_state <= S_SHARE;
                    end else begin
                        r_i     <= w_i_p1;
                        r_state <= S_BIG_RD;
                    end
                end
                // share over the entries that were not set aside
                S_SHARE: begin
                    if ((TGT_W+1)'(r_big_n) < {1'b0, r_bk}) begin
                        r_sp <= r_total - r_big_sum;
                        r_sd <= r_bk - r_big_n[TGT_W-1:0];
                    end else begin
                        r_sp <= r_total;
                        r_sd <= r_bk;
                    end
                    r_state <= S_W_RD;
                end
                // fetch current and next entries
                S_W_RD: begin
                    r_state <= S_W_CUR;
                end
                S_W_CUR: begin
                    r_prev_v <= r_cur_v;
                    r_cur_v  <= w_q_v;
                    r_cur_n  <= w_q_n;
                    r_state  <= S_W_NXT;
                end
                S_W_NXT: begin
                    r_nxt_v <= w_q_v;
                    r_nxt_n <= w_q_n;
                    r_state <= r_mode_mid ? S_MID : S_W_MUL;
                end
                // every midpoint
                S_MID: begin
                    r_i <= w_i_p1;
                    if (w_i_p1 + 1'b1 == r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_W_RD;
                    end
                end
                // running walk
                S_W_MUL: begin
                    r_num   <= r_num + TOT_W'(r_cur_n);
                    r_prod  <= {{(32-NUM_W){1'b0}}, r_cur_n} * {{(32-TGT_W){1'b0}}, r_sd};
                    r_state <= S_W_FIRST;
                end
                S_W_FIRST: begin
                    if (w_first) begin
                        r_num <= r_num - TOT_W'(r_cur_n);
                    end
                    r_state <= S_W_MUL2;
                end
                S_W_MUL2: begin
                    r_prod2 <= {{TGT_W{1'b0}}, r_num} * {{TOT_W{1'b0}}, r_sd};
                    r_prod  <= {{(32-NUM_W){1'b0}}, r_nxt_n} * {{(32-TGT_W){1'b0}}, r_sd};
                    r_state <= S_W_SECOND;
                end
                S_W_SECOND: begin
                    if (w_second) begin
                        r_num <= '0;
                    end
                    if (w_i_p1 == r_n) begin
                        r_state <= S_DONE;
                    end else begin
                        r_i     <= w_i_p1;
                        r_state <= S_W_RD;
                    end
                end
                // duplicate or empty answers collapse to one beat
                S_DONE: begin
                    r_k <= '0;
                    if (r_dup || (r_len == '0)) begin
                        r_err   <= r_dup ? ERR_DUP : ERR_NONE;
                        r_state <= S_ONE;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                S_ONE: begin
                    if (i_res_space) begin
                        r_state <= S_IDLE;
                    end
                end
                // read a split, then write it to the result queue
                S_E_RD: begin
                    if (r_e_wr) begin
                        r_e_wr <= 1'b0;
                        r_k    <= w_k_p1;
                        if (w_k_p1 == w_lim) begin
                            r_state <= S_IDLE;
                        end
                    end else if (i_res_space) begin
                        r_e_wr <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[design/frequency_bucket_splitter.sv]
// ----------------------------------------------------------------------------
// frequency_bucket_splitter: equal-frequency bucket boundaries
// Loads a run of ascending values with counts and sends the split points.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: drive push with entry_value/count/last while full is low;
//   one beat is taken per cycle while a run loads. The beat with entry_last
//   closes the run. full then stays high while the walker reads the stored
//   entries: an oversize-count pass, then the running walk, or a single
//   midpoint pass when every midpoint is a split; the pace is set by the
//   single read port of the entry store and the share multiplier.
//   After the walk a new run may load while the answer drains.
//   Result channel: empty low shows a beat; pop takes it. Splits leave the
//   split buffer through a two-entry queue; each is read, then written.
//   A stalled receiver holds the beat on the ports and pauses the sender.
//   Configuration: i_cfg_we writes target_buckets; write only
//   while the block is idle.
//   Reset (synchronous, active low) empties the queues, clears the run and
//   sets target_buckets to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module frequency_bucket_splitter import fbs_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic signed [VAL_W-1:0] i_entry_value,
    input  wire logic [NUM_W-1:0]        i_entry_count,
    input  wire logic                    i_entry_last,
    output logic                         empty,
    input  wire logic                    pop,
    output logic signed [VAL_W-1:0]      o_split_value,
    output logic                         o_has_split,
    output logic                         o_result_last,
    output logic [1:0]                   o_error_code,
    input  wire logic                    i_cfg_we,
    input  wire logic [TGT_W-1:0]        i_cfg_wdata
);

    logic [TGT_W-1:0] r_target;

    logic             w_walk_busy;
    logic             w_job_take;
    logic             w_job_valid;
    t_job             w_job;
    logic             w_ent_we;
    logic [IDX_W-1:0] w_ent_waddr;
    logic [ENT_W-1:0] w_ent_wdata;
    logic             w_ent_re;
    logic [IDX_W-1:0] w_ent_raddr;
    logic [ENT_W-1:0] w_ent_rdata;
    logic             w_res_wr;
    t_result          w_res;
    logic             w_res_space;
    t_result          w_head;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TGT_RESET;
        end else if (i_cfg_we) begin
            r_target <= i_cfg_wdata;
        end
    end

    fbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_entry_value(i_entry_value),
        .i_entry_count(i_entry_count),
        .i_entry_last (i_entry_last),
        .i_walk_busy  (w_walk_busy),
        .i_job_take   (w_job_take),
        .o_job_valid  (w_job_valid),
        .o_job        (w_job),
        .o_we         (w_ent_we),
        .o_waddr      (w_ent_waddr),
        .o_wdata      (w_ent_wdata)
    );

    // entry store: value and count side by side
    fbs_ram #(
        .WIDTH(ENT_W),
        .DEPTH(MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk  (i_clk),
        .i_we   (w_ent_we),
        .i_waddr(w_ent_waddr),
        .i_wdata(w_ent_wdata),
        .i_re   (w_ent_re),
        .i_raddr(w_ent_raddr),
        .o_rdata(w_ent_rdata)
    );

    fbs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_job_valid),
        .i_job      (w_job),
        .o_job_take (w_job_take),
        .o_walk_busy(w_walk_busy),
        .i_target   (r_target),
        .o_ent_re   (w_ent_re),
        .o_ent_raddr(w_ent_raddr),
        .i_ent_rdata(w_ent_rdata),
        .o_res_wr   (w_res_wr),
        .o_res      (w_res),
        .i_res_space(w_res_space)
    );

    fbs_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (w_res_wr),
        .i_item (w_res),
        .o_space(w_res_space),
        .o_empty(empty),
        .i_pop  (pop),
        .o_item (w_head)
    );

    assign o_split_value = w_head.value;
    assign o_has_split   = w_head.has;
    assign o_result_last = w_head.last;
    assign o_error_code  = w_head.err;

endmodule
`default_nettype wire

[design/fbs_checker.sv]
// ----------------------------------------------------------------------------
// fbs_checker: port-level checks
// Watches the result channel of the splitter over time.
// ----------------------------------------------------------------------------
`default_nettype none
module fbs_checker import fbs_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    empty,
    input wire logic                    pop,
    input wire logic signed [VAL_W-1:0] o_split_value,
    input wire logic                    o_has_split,
    input wire logic                    o_result_last,
    input wire logic [1:0]              o_error_code
);

    // reset leaves no stale beat behind
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // an error answer is a lone beat without a split
    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_error_code != ERR_NONE)) |-> (!o_has_split && o_result_last))
        else $error("error beat carries a split or is not last");

    // a beat without a split closes the answer and shows zero
    a_empty_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_split) |-> (o_result_last && (o_split_value == '0)))
        else $error("beat without split is malformed");

    // a stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_split_value)))
        else $error("stalled result beat changed");

endmodule

bind frequency_bucket_splitter fbs_checker u_fbs_checker (.*);
`default_nettype wire
